/* src/length_prefixed_frame_receiver_top_macros.svh */
// Assertion macros for the length-prefixed frame receiver.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_TOP_MACROS_SVH

// Condition must never be true outside reset.
`define LPFR_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lpfr assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define LPFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfr assertion failed");

// Antecedent implies consequent in the same cycle.
`define LPFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfr assertion failed");

`endif

/* src/lpfr_pkg.sv */
// Shared types and constants for the length-prefixed frame receiver.
package lpfr_pkg;

  localparam logic [7:0] HEADER_RESET    = 8'd90;
  localparam logic [7:0] MASK_RESET      = 8'd127;
  localparam logic [7:0] PAYLOAD_START   = 8'd5;

  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW        = FIFO_AW + 1;

  // Configuration register indexes
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_MASK   = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN     = 2'd1,
    PH_CONTENT = 2'd2,
    PH_SUM     = 2'd3
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  // One queued result, command not yet masked
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  command;
    logic [7:0]  plen;
    status_t     status;
  } entry_t;

  // Queue state seen by the back end
  typedef struct packed {
    logic                 valid;
    logic [FIFO_CW-1:0]   level;
  } q_stat_t;

endpackage

/* src/lpfr_front.sv */
// Front end: frame parser that classifies each received byte and queues results.
module lpfr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           header_byte,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 q_full,
  output logic                 push,
  output lpfr_pkg::entry_t     push_entry
);

  lpfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       accept;
  logic [8:0] pos_inc;

  assign in_tready = rst_n && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign pos_inc   = {1'b0, pos_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpfr_pkg::PH_HUNT;
      len_r   <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
      cmd_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    cmd_nxt    = cmd_r;
    push       = 1'b0;
    push_entry = '{kind: lpfr_pkg::KIND_PAYLOAD, data: in_tdata, command: cmd_r,
                   plen: 8'd0, status: lpfr_pkg::ST_OK};
    if (accept) begin
      case (phase_r)
        lpfr_pkg::PH_HUNT: begin
          if (in_tdata == header_byte) begin
            phase_nxt = lpfr_pkg::PH_LEN;
            len_nxt   = '0;
            pos_nxt   = '0;
            sum_nxt   = '0;
            cmd_nxt   = '0;
          end
        end
        lpfr_pkg::PH_LEN: begin
          len_nxt   = in_tdata;
          pos_nxt   = '0;
          sum_nxt   = in_tdata;
          phase_nxt = (in_tdata == 8'd0) ? lpfr_pkg::PH_SUM : lpfr_pkg::PH_CONTENT;
        end
        lpfr_pkg::PH_CONTENT: begin
          // last content byte is left out of the sum
          if (pos_inc < {1'b0, len_r}) sum_nxt = sum_r + in_tdata;
          if (pos_r == 8'd0) begin
            cmd_nxt            = in_tdata;
            push_entry.command = in_tdata;
          end
          if (pos_r >= lpfr_pkg::PAYLOAD_START) push = 1'b1;
          pos_nxt = pos_inc[7:0];
          if (pos_inc >= {1'b0, len_r}) phase_nxt = lpfr_pkg::PH_SUM;
        end
        lpfr_pkg::PH_SUM: begin
          push            = 1'b1;
          push_entry.kind = lpfr_pkg::KIND_END;
          push_entry.data = 8'd0;
          if (len_r < lpfr_pkg::PAYLOAD_START) begin
            push_entry.status = lpfr_pkg::ST_SHORT;
          end else begin
            push_entry.plen   = len_r - lpfr_pkg::PAYLOAD_START;
            push_entry.status = (sum_r == in_tdata) ? lpfr_pkg::ST_OK
                                                    : lpfr_pkg::ST_BAD_SUM;
          end
          phase_nxt = lpfr_pkg::PH_HUNT;
        end
        default: phase_nxt = lpfr_pkg::PH_HUNT;
      endcase
    end
  end

endmodule

/* src/lpfr_fifo.sv */
// Short result queue between parser and output stage.
module lpfr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lpfr_pkg::entry_t     push_entry,
  output logic                 full,
  input  logic                 pop,
  output lpfr_pkg::entry_t     head,
  output lpfr_pkg::q_stat_t    stat
);

  lpfr_pkg::entry_t mem_r [lpfr_pkg::FIFO_DEPTH];
  logic [lpfr_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  logic [lpfr_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == lpfr_pkg::FIFO_CW'(lpfr_pkg::FIFO_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (cnt_r != '0);
  assign head    = mem_r[rptr_r];
  assign stat    = '{valid: (cnt_r != '0), level: cnt_r};

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/lpfr_back.sv */
// Back end: applies the command mask and holds the result beat for the sink.
module lpfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           command_mask,
  input  lpfr_pkg::q_stat_t    q_stat,
  input  lpfr_pkg::entry_t     head,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  output logic                 out_tuser
);

  logic             valid_r;
  lpfr_pkg::entry_t res_r;

  assign pop        = q_stat.valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {6'd0, res_r.status, res_r.plen, res_r.command, res_r.data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= '{kind: head.kind, data: head.data, command: head.command & command_mask,
                 plen: head.plen, status: head.status};
    end
  end

endmodule

/* src/length_prefixed_frame_receiver_top.sv */
// Top level of the length-prefixed frame receiver.
// Takes one received byte per beat and emits payload bytes and a frame-end beat per frame
// (tuser 0 payload, 1 frame end). One byte is accepted every cycle: the parser handles a
// byte as it arrives and a four-entry queue plus an output register carry results, so
// in_tready drops only in reset or when the queue is full because the sink is stalling. A
// result beat is queued when its byte is accepted and registered in the output register
// before it is offered. Configuration (index 0 header byte, index 1 command mask) is
// accepted whenever out of reset and should be written only while the block is idle.
`include "length_prefixed_frame_receiver_top_macros.svh"
module length_prefixed_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] received_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] payload_byte, [15:8] command_type,
                                   // [23:16] payload_length, [25:24] frame_status, zeros
  output logic        out_tuser,   // [0] result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] header_r;
  logic [7:0] mask_r;
  logic              q_full;
  logic              push;
  lpfr_pkg::entry_t  push_entry;
  logic              pop;
  lpfr_pkg::entry_t  head;
  lpfr_pkg::q_stat_t q_stat;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= lpfr_pkg::HEADER_RESET;
      mask_r   <= lpfr_pkg::MASK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lpfr_pkg::REG_HEADER: header_r <= cfg_data;
        lpfr_pkg::REG_MASK:   mask_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  lpfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .header_byte(header_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lpfr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  lpfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .command_mask(mask_r),
    .q_stat      (q_stat),
    .head        (head),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  `LPFR_ASSERT_NEVER(a_q_level, q_stat.level > lpfr_pkg::FIFO_CW'(lpfr_pkg::FIFO_DEPTH))
  `LPFR_ASSERT_NEXT(a_pop_shows, pop, out_tvalid)
  `LPFR_ASSERT_SAME(a_short_len,
    push && push_entry.kind == lpfr_pkg::KIND_END && push_entry.status == lpfr_pkg::ST_SHORT,
    push_entry.plen == 8'd0)
  `LPFR_ASSERT_NEVER(a_push_full, push && q_full)

endmodule

/* tb/tb_length_prefixed_frame_receiver_top.sv */
// Self-checking testbench for the length-prefixed frame receiver: directed frames, then random.
module tb_length_prefixed_frame_receiver_top;

  localparam int STALL_LIMIT  = 1000;  // cycles with no beat on any channel
  localparam int DRAIN_CYCLES = 6;
  localparam int NUM_DIRECTED = 26;

  typedef struct packed {
    lpfr_pkg::kind_t   kind;
    logic [7:0]        data;
    logic [7:0]        cmd;
    logic [7:0]        plen;
    lpfr_pkg::status_t st;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;   // beat below is the expected result of this byte
    rx_beat_t   beat;
  } dir_row_t;

  localparam rx_beat_t NO_BEAT = '{lpfr_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h00,
                                   lpfr_pkg::ST_OK};

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = lpfr_pkg::REG_HEADER;
  logic [7:0]  cfg_data   = 8'h00;

  length_prefixed_frame_receiver_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted receiver state and register copies
  logic [7:0]       hdr_reg   = lpfr_pkg::HEADER_RESET;
  logic [7:0]       mask_reg  = lpfr_pkg::MASK_RESET;
  lpfr_pkg::phase_t rx_phase  = lpfr_pkg::PH_HUNT;
  logic [7:0]       rx_len    = 8'h00;
  logic [7:0]       rx_pos    = 8'h00;
  logic [7:0]       rx_sum    = 8'h00;
  logic [7:0]       rx_cmd    = 8'h00;

  rx_beat_t pending_beats[$];
  int       errors      = 0;
  int       bytes_sent  = 0;
  int       frame_bytes = 0;
  int       n_payload   = 0;
  int       n_ok        = 0;
  int       n_bad_sum   = 0;
  int       n_short     = 0;
  bit       idling_on   = 1'b1;

  // Header 0x5A, mask 0x7F (reset values)
  dir_row_t dir_rows [NUM_DIRECTED] = '{
    '{8'hFF, 1'b0, NO_BEAT},                                        // noise while hunting
    '{8'h5A, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},                                        // zero length
    '{8'h00, 1'b1, '{lpfr_pkg::KIND_END, 8'h00, 8'h00, 8'h00, lpfr_pkg::ST_SHORT}},
    '{8'h5A, 1'b0, NO_BEAT},
    '{8'h07, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, NO_BEAT},                                        // command
    '{8'h5A, 1'b0, NO_BEAT},                                        // header value in the id
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'hFF, 1'b1, '{lpfr_pkg::KIND_PAYLOAD, 8'hFF, 8'h7F, 8'h00, lpfr_pkg::ST_OK}},
    '{8'h00, 1'b1, '{lpfr_pkg::KIND_PAYLOAD, 8'h00, 8'h7F, 8'h00, lpfr_pkg::ST_OK}},
    '{8'h5F, 1'b0, NO_BEAT},                                        // good checksum
    '{8'h5A, 1'b0, NO_BEAT},
    '{8'h01, 1'b0, NO_BEAT},                                        // short, sum also wrong
    '{8'h80, 1'b0, NO_BEAT},
    '{8'h33, 1'b1, '{lpfr_pkg::KIND_END, 8'h00, 8'h00, 8'h00, lpfr_pkg::ST_SHORT}},
    '{8'h5A, 1'b0, NO_BEAT},
    '{8'h05, 1'b0, NO_BEAT},                                        // no payload, bad sum
    '{8'h81, 1'b0, NO_BEAT},
    '{8'h12, 1'b0, NO_BEAT},
    '{8'h34, 1'b0, NO_BEAT},
    '{8'h56, 1'b0, NO_BEAT},
    '{8'h78, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, '{lpfr_pkg::KIND_END, 8'h00, 8'h01, 8'h00, lpfr_pkg::ST_BAD_SUM}}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the receiver by one byte; returns 1 when the byte yields a result beat
  function automatic bit parse_byte(input logic [7:0] b, output rx_beat_t beat);
    bit got;
    got  = 1'b0;
    beat = NO_BEAT;
    case (rx_phase)
      lpfr_pkg::PH_HUNT: begin
        if (b == hdr_reg) begin
          rx_phase = lpfr_pkg::PH_LEN;
          rx_len   = 8'h00;
          rx_pos   = 8'h00;
          rx_sum   = 8'h00;
          rx_cmd   = 8'h00;
        end
      end
      lpfr_pkg::PH_LEN: begin
        rx_len   = b;
        rx_pos   = 8'h00;
        rx_sum   = b;
        rx_phase = (b == 8'h00) ? lpfr_pkg::PH_SUM : lpfr_pkg::PH_CONTENT;
      end
      lpfr_pkg::PH_CONTENT: begin
        // last content byte is left out of the sum
        if ({1'b0, rx_pos} + 9'd1 < {1'b0, rx_len}) rx_sum = rx_sum + b;
        if (rx_pos == 8'h00) rx_cmd = b;
        if (rx_pos >= lpfr_pkg::PAYLOAD_START) begin
          got       = 1'b1;
          beat.kind = lpfr_pkg::KIND_PAYLOAD;
          beat.data = b;
          beat.cmd  = rx_cmd & mask_reg;
        end
        rx_pos = rx_pos + 8'd1;
        if (rx_pos >= rx_len) rx_phase = lpfr_pkg::PH_SUM;
      end
      default: begin
        got       = 1'b1;
        beat.kind = lpfr_pkg::KIND_END;
        beat.cmd  = rx_cmd & mask_reg;
        if (rx_len < lpfr_pkg::PAYLOAD_START) begin
          beat.st = lpfr_pkg::ST_SHORT;
        end else begin
          beat.plen = rx_len - lpfr_pkg::PAYLOAD_START;
          beat.st   = (rx_sum == b) ? lpfr_pkg::ST_OK : lpfr_pkg::ST_BAD_SUM;
        end
        rx_phase = lpfr_pkg::PH_HUNT;
      end
    endcase
    return got;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH at %0t: %s got 0x%02h expected 0x%02h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed, input rx_beat_t typed_beat);
    rx_beat_t beat;
    bit       got;
    if (idling_on && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 19)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (rx_phase != lpfr_pkg::PH_HUNT || b == hdr_reg) frame_bytes++;
    bytes_sent++;
    got = parse_byte(b, beat);
    if (typed) pending_beats = {pending_beats, typed_beat};
    else if (got) pending_beats = {pending_beats, beat};
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == lpfr_pkg::REG_HEADER) hdr_reg = val;
    else mask_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; some noise, bad sums and cut-off frames
  task automatic send_frame();
    logic [7:0] fb [0:257];
    logic [7:0] sum;
    logic [7:0] b;
    int         len, pick, total, i;
    repeat ($urandom_range(0, 2)) begin
      do b = 8'($urandom); while (b == hdr_reg);
      send_byte(b, 1'b0, NO_BEAT);
    end
    pick = $urandom_range(0, 99);
    if (pick < 8)       len = $urandom_range(0, 4);
    else if (pick < 96) len = $urandom_range(5, 24);
    else if (pick < 98) len = $urandom_range(200, 254);
    else                len = 255;
    fb[0] = hdr_reg;
    fb[1] = 8'(len);
    sum   = 8'(len);
    for (i = 0; i < len; i++) begin
      fb[2 + i] = ($urandom_range(0, 9) == 0) ? hdr_reg : 8'($urandom);
      if (i + 1 < len) sum = sum + fb[2 + i];
    end
    fb[len + 2] = ($urandom_range(0, 4) == 0) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    total = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len + 2) : len + 3;
    for (i = 0; i < total; i++) send_byte(fb[i], 1'b0, NO_BEAT);
  endtask

  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idling_on && $urandom_range(0, 11) == 0) stall = $urandom_range(1, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : monitor
    rx_beat_t got;
    rx_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.kind = lpfr_pkg::kind_t'(out_tuser);
        got.data = out_tdata[7:0];
        got.cmd  = out_tdata[15:8];
        got.plen = out_tdata[23:16];
        got.st   = lpfr_pkg::status_t'(out_tdata[25:24]);
        if (pending_beats.size() == 0) begin
          flag_mismatch("unexpected beat, payload", got.data, 8'h00);
        end else begin
          want = pending_beats.pop_front();
          if (got.kind != want.kind) flag_mismatch("kind", 8'(got.kind), 8'(want.kind));
          if (got.data != want.data) flag_mismatch("payload_byte", got.data, want.data);
          if (got.cmd != want.cmd) flag_mismatch("command_type", got.cmd, want.cmd);
          if (got.plen != want.plen) flag_mismatch("payload_length", got.plen, want.plen);
          if (got.st != want.st) flag_mismatch("frame_status", 8'(got.st), 8'(want.st));
          if (want.kind == lpfr_pkg::KIND_PAYLOAD) n_payload++;
          else if (want.st == lpfr_pkg::ST_OK) n_ok++;
          else if (want.st == lpfr_pkg::ST_BAD_SUM) n_bad_sum++;
          else n_short++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] set_hdr [4];
    logic [7:0] set_mask [4];
    int         p, target;
    set_hdr  = '{8'h00, 8'hFF, 8'($urandom), lpfr_pkg::HEADER_RESET};
    set_mask = '{8'hFF, 8'h00, 8'($urandom), lpfr_pkg::MASK_RESET};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].beat);
    drain();

    for (p = 0; p < 4; p++) begin
      if (p == 3) idling_on = 1'b0;
      write_reg(lpfr_pkg::REG_HEADER, set_hdr[p]);
      write_reg(lpfr_pkg::REG_MASK, set_mask[p]);
      target = frame_bytes + 350;
      while (frame_bytes < target) send_frame();
      drain();
    end

    $display("Sent %0d bytes (%0d inside frames) under reset and 4 register settings",
             bytes_sent, frame_bytes);
    $display("Checked %0d payload beats; frame ends: %0d ok, %0d bad sum, %0d short",
             n_payload, n_ok, n_bad_sum, n_short);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
